// ===== rtl/multiblock_reassembly_fsm_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MULTIBLOCK_REASSEMBLY_FSM_ASSERT_SVH
`define MULTIBLOCK_REASSEMBLY_FSM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBR_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mbr_pkg.sv =====
package mbr_pkg;

    localparam int BLOCK_BITS = 64;
    localparam int POS_W      = 2;
    localparam int MOD_W      = 8;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 3;
    // deepest store that still keeps a delivered frame at eight words
    localparam int MAX_STORE  = 9;

    localparam int IN_DATA_W    = 72;
    localparam int OUT_MOD_LSB  = 64;
    localparam int OUT_IDX_LSB  = 72;
    localparam int OUT_SEG_BIT  = 75;
    localparam int OUT_FIELDS_W = 76;
    localparam int OUT_DATA_W   = 80;

    localparam logic [POS_W-1:0] POS_SINGLE = 2'd0;
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd1;
    localparam logic [POS_W-1:0] POS_MIDDLE = 2'd2;
    localparam logic [POS_W-1:0] POS_END    = 2'd3;

    localparam logic [KIND_W-1:0] KIND_BLOCK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEQ      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PARITY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_OPEN  = 5'b00010,
        PH_LONG  = 5'b00100,
        PH_CHECK = 5'b01000,
        PH_MORE  = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAKE,
        OP_CLASSIFY,
        OP_PUSH,
        OP_SETUP,
        OP_EMIT,
        OP_ERR
    } op_t;

    typedef enum logic [2:0] {
        C_STEP,
        C_ALWAYS,
        C_NO_VALID,
        C_SEQ_ERR,
        C_FULL,
        C_NO_DELIVER,
        C_PAR_BAD,
        C_MORE
    } cond_t;

    typedef enum logic [1:0] {
        SEG_ZERO,
        SEG_ONE,
        SEG_VERDICT
    } seg_sel_t;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] U_FETCH    = 4'd0;
    localparam logic [STEP_W-1:0] U_CLASSIFY = 4'd1;
    localparam logic [STEP_W-1:0] U_ROOM     = 4'd2;
    localparam logic [STEP_W-1:0] U_PUSH     = 4'd3;
    localparam logic [STEP_W-1:0] U_PARITY   = 4'd4;
    localparam logic [STEP_W-1:0] U_SETUP    = 4'd5;
    localparam logic [STEP_W-1:0] U_EMIT     = 4'd6;
    localparam logic [STEP_W-1:0] U_RETURN   = 4'd7;
    localparam logic [STEP_W-1:0] U_SEQ      = 4'd8;
    localparam logic [STEP_W-1:0] U_OVF      = 4'd9;
    localparam logic [STEP_W-1:0] U_PAR      = 4'd10;

    typedef struct packed {
        op_t                op;
        cond_t              cond;
        logic [STEP_W-1:0]  target;
        logic [KIND_W-1:0]  kind;
        seg_sel_t           seg_sel;
    } ucode_t;

    typedef struct packed {
        op_t                op;
        logic [KIND_W-1:0]  kind;
        seg_sel_t           seg_sel;
        logic               go;
    } ctl_t;

    typedef struct packed {
        logic no_valid;
        logic seq_err;
        logic full;
        logic no_deliver;
        logic par_bad;
        logic more;
        logic out_busy;
    } stat_t;

    // Control store. A word jumps to target when its condition holds,
    // otherwise falls through to the next step.
    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NONE, cond: C_STEP, target: U_FETCH, kind: KIND_BLOCK,
              seg_sel: SEG_ZERO};
        unique case (step)
            U_FETCH:
            begin
                w.op     = OP_TAKE;
                w.cond   = C_NO_VALID;
                w.target = U_FETCH;
            end
            U_CLASSIFY:
            begin
                w.op     = OP_CLASSIFY;
                w.cond   = C_SEQ_ERR;
                w.target = U_SEQ;
            end
            U_ROOM:
            begin
                w.cond   = C_FULL;
                w.target = U_OVF;
            end
            U_PUSH:
            begin
                w.op     = OP_PUSH;
                w.cond   = C_NO_DELIVER;
                w.target = U_FETCH;
            end
            U_PARITY:
            begin
                w.cond   = C_PAR_BAD;
                w.target = U_PAR;
            end
            U_SETUP:
            begin
                w.op     = OP_SETUP;
            end
            U_EMIT:
            begin
                w.op     = OP_EMIT;
                w.cond   = C_MORE;
                w.target = U_EMIT;
            end
            U_RETURN:
            begin
                w.cond   = C_ALWAYS;
                w.target = U_FETCH;
            end
            U_SEQ:
            begin
                w.op      = OP_ERR;
                w.cond    = C_ALWAYS;
                w.target  = U_FETCH;
                w.kind    = KIND_SEQ;
                w.seg_sel = SEG_VERDICT;
            end
            U_OVF:
            begin
                w.op      = OP_ERR;
                w.cond    = C_ALWAYS;
                w.target  = U_FETCH;
                w.kind    = KIND_OVERFLOW;
                w.seg_sel = SEG_ONE;
            end
            U_PAR:
            begin
                w.op      = OP_ERR;
                w.cond    = C_ALWAYS;
                w.target  = U_FETCH;
                w.kind    = KIND_PARITY;
                w.seg_sel = SEG_ZERO;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = U_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/mbr_ram.sv =====
module mbr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/mbr_sequencer.sv =====
module mbr_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  mbr_pkg::stat_t stat,
    output mbr_pkg::ctl_t  ctl
);

    logic [mbr_pkg::STEP_W-1:0] pc_reg;
    logic [mbr_pkg::STEP_W-1:0] pc_next;
    mbr_pkg::ucode_t            word;
    logic                       hold;
    logic                       jump;

    assign word = mbr_pkg::ucode(pc_reg);

    // output-producing steps wait for a free output register
    assign hold = ((word.op == mbr_pkg::OP_EMIT) || (word.op == mbr_pkg::OP_ERR))
                  && stat.out_busy;

    always_comb
    begin
        unique case (word.cond)
            mbr_pkg::C_STEP:       jump = 1'b0;
            mbr_pkg::C_ALWAYS:     jump = 1'b1;
            mbr_pkg::C_NO_VALID:   jump = stat.no_valid;
            mbr_pkg::C_SEQ_ERR:    jump = stat.seq_err;
            mbr_pkg::C_FULL:       jump = stat.full;
            mbr_pkg::C_NO_DELIVER: jump = stat.no_deliver;
            mbr_pkg::C_PAR_BAD:    jump = stat.par_bad;
            mbr_pkg::C_MORE:       jump = stat.more;
            default:               jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (jump)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + mbr_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= mbr_pkg::U_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctl = '{op: word.op, kind: word.kind, seg_sel: word.seg_sel, go: !hold};

endmodule

// ===== rtl/multiblock_reassembly_fsm.sv =====
// Multiblock frame reassembly. Each input word is a 64-bit block with its
// position code and frame modulo; single, double and long frames are rebuilt
// in a block store of min(MAX_BLOCKS, 9) entries, a long frame being checked
// by the XOR of all its blocks including the closing parity block. A complete
// frame leaves as a run of words, tlast on the final one; a sequence, parity
// or overflow error leaves as one word with tlast set. A small microprogram
// drives the datapath through fetch, classify, room, push, parity, setup and
// emit steps, one stored block read per cycle through the single store read
// port while the output is not stalled. A new input is taken while the last
// output word still waits in the output register.
module multiblock_reassembly_fsm #(
    parameter int MAX_BLOCKS = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // block_bits[63:0], frame_modulo[71:64]
    input  logic [mbr_pkg::IN_DATA_W-1:0]   s_tdata,
    // position_code[1:0]
    input  logic [mbr_pkg::POS_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // payload[63:0], start_modulo[71:64], block_index[74:72], seg_reset[75],
    // zero[79:76]
    output logic [mbr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // kind[1:0]
    output logic [mbr_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast
);

    localparam int STORE_LIMIT = (MAX_BLOCKS < mbr_pkg::MAX_STORE) ? MAX_BLOCKS
                                                                   : mbr_pkg::MAX_STORE;
    localparam int CNT_W  = $clog2(STORE_LIMIT + 1);
    localparam int ADDR_W = $clog2(STORE_LIMIT);
    localparam int PAD_W  = mbr_pkg::OUT_DATA_W - mbr_pkg::OUT_FIELDS_W;

    mbr_pkg::ctl_t  ctl;
    mbr_pkg::stat_t stat;

    // current input word
    logic [mbr_pkg::BLOCK_BITS-1:0] bits_reg;
    logic [mbr_pkg::POS_W-1:0]      pos_reg;
    logic [mbr_pkg::MOD_W-1:0]      mod_reg;

    mbr_pkg::phase_t                phase_reg;
    mbr_pkg::phase_t                phase_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [mbr_pkg::BLOCK_BITS-1:0] parity_reg;
    logic [mbr_pkg::BLOCK_BITS-1:0] parity_next;
    logic [mbr_pkg::MOD_W-1:0]      cmod_reg;
    logic [mbr_pkg::MOD_W-1:0]      cmod_next;

    // decision for the current word
    logic            v_seg_reg;
    logic            v_deliver_reg;
    logic            v_minus1_reg;
    logic            v_check_reg;
    mbr_pkg::phase_t v_phase_reg;
    logic            d_seq;
    logic            d_seg;
    logic            d_deliver;
    logic            d_minus1;
    logic            d_check;
    mbr_pkg::phase_t d_phase;

    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] idx_inc;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [mbr_pkg::KIND_W-1:0]     out_kind_reg;
    logic [mbr_pkg::BLOCK_BITS-1:0] out_payload_reg;
    logic [mbr_pkg::MOD_W-1:0]      out_mod_reg;
    logic [mbr_pkg::IDX_W-1:0]      out_idx_reg;
    logic                           out_seg_reg;
    logic                           out_last_reg;
    logic                           err_seg;

    logic take_go;
    logic classify_go;
    logic push_go;
    logic setup_go;
    logic emit_go;
    logic err_go;
    logic more;

    logic                           ram_wr_en;
    logic                           ram_rd_en;
    logic [ADDR_W-1:0]              ram_rd_addr;
    logic [mbr_pkg::BLOCK_BITS-1:0] ram_rd_data;

    assign take_go     = ctl.go && (ctl.op == mbr_pkg::OP_TAKE);
    assign classify_go = ctl.go && (ctl.op == mbr_pkg::OP_CLASSIFY);
    assign push_go     = ctl.go && (ctl.op == mbr_pkg::OP_PUSH);
    assign setup_go    = ctl.go && (ctl.op == mbr_pkg::OP_SETUP);
    assign emit_go     = ctl.go && (ctl.op == mbr_pkg::OP_EMIT);
    assign err_go      = ctl.go && (ctl.op == mbr_pkg::OP_ERR);

    assign s_tready = take_go;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign more    = (idx_inc != len_reg);

    always_comb
    begin
        d_seq     = 1'b0;
        d_seg     = 1'b1;
        d_deliver = 1'b0;
        d_minus1  = 1'b0;
        d_check   = 1'b0;
        d_phase   = mbr_pkg::PH_IDLE;
        unique case (phase_reg)
            mbr_pkg::PH_OPEN:
            begin
                if (pos_reg == mbr_pkg::POS_MIDDLE)
                begin
                    d_phase = mbr_pkg::PH_LONG;
                end
                else if (pos_reg == mbr_pkg::POS_END)
                begin
                    d_deliver = 1'b1;
                end
                else
                begin
                    d_seq = 1'b1;
                end
            end
            mbr_pkg::PH_LONG, mbr_pkg::PH_MORE:
            begin
                if (pos_reg == mbr_pkg::POS_MIDDLE)
                begin
                    d_phase = mbr_pkg::PH_CHECK;
                end
                else if (pos_reg == mbr_pkg::POS_END)
                begin
                    d_phase = mbr_pkg::PH_MORE;
                end
                else
                begin
                    d_seq = 1'b1;
                    // right after the first middle block no reset is asked
                    d_seg = (phase_reg != mbr_pkg::PH_LONG);
                end
            end
            mbr_pkg::PH_CHECK:
            begin
                if (pos_reg == mbr_pkg::POS_FIRST)
                begin
                    d_deliver = 1'b1;
                    d_minus1  = 1'b1;
                    d_check   = 1'b1;
                end
                else
                begin
                    d_seq = 1'b1;
                end
            end
            default:
            begin
                if (pos_reg == mbr_pkg::POS_SINGLE)
                begin
                    d_deliver = 1'b1;
                end
                else if (pos_reg == mbr_pkg::POS_FIRST)
                begin
                    d_phase = mbr_pkg::PH_OPEN;
                end
                else
                begin
                    d_seq = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        parity_next = parity_reg;
        cmod_next   = cmod_reg;
        if (classify_go && (phase_reg == mbr_pkg::PH_IDLE))
        begin
            count_next  = '0;
            parity_next = '0;
            cmod_next   = mod_reg;
        end
        if (push_go)
        begin
            count_next  = count_reg + CNT_W'(1);
            parity_next = parity_reg ^ bits_reg;
            phase_next  = v_phase_reg;
        end
        if (err_go)
        begin
            phase_next = mbr_pkg::PH_IDLE;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        idx_next = idx_reg;
        if (setup_go)
        begin
            len_next = count_reg - CNT_W'(v_minus1_reg);
            idx_next = '0;
        end
        else if (emit_go)
        begin
            idx_next = idx_inc;
        end
    end

    always_comb
    begin
        unique case (ctl.seg_sel)
            mbr_pkg::SEG_ZERO:    err_seg = 1'b0;
            mbr_pkg::SEG_ONE:     err_seg = 1'b1;
            mbr_pkg::SEG_VERDICT: err_seg = v_seg_reg;
            default:              err_seg = 1'b0;
        endcase
    end

    always_comb
    begin
        if (emit_go || err_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mbr_pkg::PH_IDLE;
            count_reg     <= '0;
            parity_reg    <= '0;
            cmod_reg      <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            v_seg_reg     <= 1'b0;
            v_deliver_reg <= 1'b0;
            v_minus1_reg  <= 1'b0;
            v_check_reg   <= 1'b0;
            v_phase_reg   <= mbr_pkg::PH_IDLE;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            parity_reg    <= parity_next;
            cmod_reg      <= cmod_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (classify_go)
            begin
                v_seg_reg     <= d_seg;
                v_deliver_reg <= d_deliver;
                v_minus1_reg  <= d_minus1;
                v_check_reg   <= d_check;
                v_phase_reg   <= d_phase;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_go && s_tvalid)
        begin
            bits_reg <= s_tdata[mbr_pkg::BLOCK_BITS-1:0];
            mod_reg  <= s_tdata[mbr_pkg::OUT_MOD_LSB +: mbr_pkg::MOD_W];
            pos_reg  <= s_tuser;
        end
        if (emit_go)
        begin
            out_kind_reg    <= mbr_pkg::KIND_BLOCK;
            out_payload_reg <= ram_rd_data;
            out_mod_reg     <= cmod_reg;
            out_idx_reg     <= mbr_pkg::IDX_W'(idx_reg);
            out_seg_reg     <= 1'b0;
            out_last_reg    <= !more;
        end
        else if (err_go)
        begin
            out_kind_reg    <= ctl.kind;
            out_payload_reg <= '0;
            out_mod_reg     <= cmod_reg;
            out_idx_reg     <= '0;
            out_seg_reg     <= err_seg;
            out_last_reg    <= 1'b1;
        end
    end

    // the sequence check is taken in the classify step itself
    assign stat = '{no_valid:   !s_tvalid,
                    seq_err:    d_seq,
                    full:       (count_reg >= CNT_W'(STORE_LIMIT)),
                    no_deliver: !v_deliver_reg,
                    par_bad:    v_check_reg && (parity_reg != '0),
                    more:       more,
                    out_busy:   out_valid_reg && !m_tready};

    // the first block is fetched during setup, each emit but the last fetches the next one
    assign ram_wr_en   = push_go;
    assign ram_rd_en   = setup_go || (emit_go && more);
    assign ram_rd_addr = setup_go ? '0 : idx_inc[ADDR_W-1:0];

    mbr_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    mbr_ram #(
        .WIDTH (mbr_pkg::BLOCK_BITS),
        .DEPTH (STORE_LIMIT)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (bits_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_seg_reg, out_idx_reg, out_mod_reg,
                       out_payload_reg};

endmodule

// ===== rtl/mbr_checker.sv =====
`include "multiblock_reassembly_fsm_assert.svh"

module mbr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mbr_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [mbr_pkg::KIND_W-1:0]     m_tuser,
    input logic                           m_tlast
);

    logic is_err;

    assign is_err = m_tvalid && (m_tuser != mbr_pkg::KIND_BLOCK);

    // an error is always a run of one word
    `MBR_ASSERT_IMPLY(a_err_last, clk, rst_n, is_err, m_tlast, "error word without tlast")

    `MBR_ASSERT_IMPLY(a_err_empty, clk, rst_n, is_err,
        (m_tdata[mbr_pkg::BLOCK_BITS-1:0] == '0) &&
        (m_tdata[mbr_pkg::OUT_IDX_LSB +: mbr_pkg::IDX_W] == '0),
        "error word carries payload or index")

    `MBR_ASSERT_IMPLY(a_block_no_seg, clk, rst_n,
        m_tvalid && (m_tuser == mbr_pkg::KIND_BLOCK),
        !m_tdata[mbr_pkg::OUT_SEG_BIT], "frame word requests segmentation reset")

    `MBR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled output word changed")

endmodule

bind multiblock_reassembly_fsm mbr_checker u_mbr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
